### hw/rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the Euler-to-quaternion block
// Fixed-point formats, the CORDIC lane type and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package e2q_pkg;

	// CORDIC datapath width (Q24 with headroom for a +-pi raw angle)
	localparam int unsigned CW = 27;
	// Sine/cosine width after the cut to Q16
	localparam int unsigned SCW = 19;
	// First-level product width (Q32)
	localparam int unsigned P1W = 2 * SCW;
	// Second-level product width (Q48)
	localparam int unsigned P2W = P1W + SCW;
	// Sum width of two second-level products
	localparam int unsigned SUMW = P2W + 1;
	// Shift from Q48 down to Q14
	localparam int unsigned OUT_SHIFT = 34;
	// Width after the shift
	localparam int unsigned SHW = SUMW - OUT_SHIFT;
	// Angle and component width
	localparam int unsigned AW = 16;
	// Raw Q13 angle to Q24 half angle
	localparam int unsigned HALF_SHIFT = 10;
	// Number of angles carried side by side (roll, pitch, yaw)
	localparam int unsigned NLANE = 3;
	localparam int unsigned ROLL = 0;
	localparam int unsigned PITCH = 1;
	localparam int unsigned YAW = 2;

	localparam logic signed [CW-1:0] Q24_PI = 27'sd52707179;
	localparam logic signed [CW-1:0] Q24_HALF_PI = 27'sd26353589;
	localparam logic signed [CW-1:0] Q24_GAIN_INV = 27'sd10188014;
	localparam logic signed [SHW-1:0] QUAT_ONE = 24'sd16384;
	localparam int unsigned ATAN_LEN = 20;

	// One CORDIC lane: vector, residual angle and quadrant-fold mark
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 flip;
	} lane_t;

	typedef lane_t [NLANE-1:0] lanes_t;

	// atan(2^-i) in Q24, rounded to nearest
	function automatic logic signed [CW-1:0] atan_q24(input int unsigned i);
		logic signed [CW-1:0] r;
		unique case (i)
			0:  r = 27'sd13176795;
			1:  r = 27'sd7778716;
			2:  r = 27'sd4110060;
			3:  r = 27'sd2086331;
			4:  r = 27'sd1047214;
			5:  r = 27'sd524117;
			6:  r = 27'sd262123;
			7:  r = 27'sd131069;
			8:  r = 27'sd65536;
			9:  r = 27'sd32768;
			10: r = 27'sd16384;
			11: r = 27'sd8192;
			12: r = 27'sd4096;
			13: r = 27'sd2048;
			14: r = 27'sd1024;
			15: r = 27'sd512;
			16: r = 27'sd256;
			17: r = 27'sd128;
			18: r = 27'sd64;
			19: r = 27'sd32;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/e2q_fold.sv
// ----------------------------------------------------------------------------
// e2q_fold: half-angle and quadrant fold stage
// Scales each raw angle to a Q24 half angle, folds it into +-pi/2 and
// loads the CORDIC start vector.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_fold (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic                                 in_v,
	input  wire logic signed [e2q_pkg::AW-1:0]        roll_angle,
	input  wire logic signed [e2q_pkg::AW-1:0]        pitch_angle,
	input  wire logic signed [e2q_pkg::AW-1:0]        yaw_angle,
	output logic                                      out_v,
	output e2q_pkg::lanes_t                           lanes_out
);

	logic signed [e2q_pkg::AW-1:0] raw [e2q_pkg::NLANE];
	e2q_pkg::lanes_t               lanes_d;
	e2q_pkg::lanes_t               lanes_s1;
	logic                          v_s1;

	assign raw[e2q_pkg::ROLL]  = roll_angle;
	assign raw[e2q_pkg::PITCH] = pitch_angle;
	assign raw[e2q_pkg::YAW]   = yaw_angle;

	// Half angle in Q24, folded into the convergence range
	always_comb begin
		logic signed [e2q_pkg::CW-1:0] z;
		for (int k = 0; k < e2q_pkg::NLANE; k++) begin
			z = e2q_pkg::CW'(raw[k]) <<< e2q_pkg::HALF_SHIFT;
			lanes_d[k].x = e2q_pkg::Q24_GAIN_INV;
			lanes_d[k].y = '0;
			if (z > e2q_pkg::Q24_HALF_PI) begin
				lanes_d[k].z    = z - e2q_pkg::Q24_PI;
				lanes_d[k].flip = 1'b1;
			end else if (z < -e2q_pkg::Q24_HALF_PI) begin
				lanes_d[k].z    = z + e2q_pkg::Q24_PI;
				lanes_d[k].flip = 1'b1;
			end else begin
				lanes_d[k].z    = z;
				lanes_d[k].flip = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_s1 <= lanes_d;
		end
	end

	assign out_v     = v_s1;
	assign lanes_out = lanes_s1;

endmodule

`default_nettype wire

### hw/rtl/e2q_cordic_cell.sv
// ----------------------------------------------------------------------------
// e2q_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotates the three angle lanes by +-atan(2^-STAGE) and registers the result
// for the next cell in the row.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_cordic_cell #(
	parameter int unsigned STAGE = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_v,
	input  wire e2q_pkg::lanes_t lanes_in,
	output logic                 out_v,
	output e2q_pkg::lanes_t      lanes_out
);

	localparam logic signed [e2q_pkg::CW-1:0] ATAN = e2q_pkg::atan_q24(STAGE);

	e2q_pkg::lanes_t lanes_d;
	e2q_pkg::lanes_t lanes_q;
	logic            v_q;

	// Micro-rotation, direction from the sign of the residual angle
	always_comb begin
		logic signed [e2q_pkg::CW-1:0] x, y, z, dx, dy;
		for (int k = 0; k < e2q_pkg::NLANE; k++) begin
			x  = lanes_in[k].x;
			y  = lanes_in[k].y;
			z  = lanes_in[k].z;
			dx = y >>> STAGE;
			dy = x >>> STAGE;
			lanes_d[k].flip = lanes_in[k].flip;
			if (z >= 0) begin
				lanes_d[k].x = x - dx;
				lanes_d[k].y = y + dy;
				lanes_d[k].z = z - ATAN;
			end else begin
				lanes_d[k].x = x + dx;
				lanes_d[k].y = y - dy;
				lanes_d[k].z = z + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_q <= lanes_d;
		end
	end

	assign out_v     = v_q;
	assign lanes_out = lanes_q;

endmodule

`default_nettype wire

### hw/rtl/e2q_quat_mult.sv
// ----------------------------------------------------------------------------
// e2q_quat_mult: sine/cosine cut and quaternion product pipeline
// Unfolds and cuts the CORDIC outputs to Q16, forms the ZYX products over
// two multiply stages, then sums, shifts to Q14 and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_quat_mult (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_v,
	input  wire e2q_pkg::lanes_t                   lanes_in,
	output logic                                   out_v,
	output logic signed [e2q_pkg::AW-1:0]          quat_w,
	output logic signed [e2q_pkg::AW-1:0]          quat_x,
	output logic signed [e2q_pkg::AW-1:0]          quat_y,
	output logic signed [e2q_pkg::AW-1:0]          quat_z
);

	localparam int unsigned SCW  = e2q_pkg::SCW;
	localparam int unsigned P1W  = e2q_pkg::P1W;
	localparam int unsigned P2W  = e2q_pkg::P2W;
	localparam int unsigned SUMW = e2q_pkg::SUMW;
	localparam int unsigned SHW  = e2q_pkg::SHW;

	logic v_s1, v_s2, v_s3, v_s4;

	// Stage 1: undo the quadrant fold and cut to Q16
	logic signed [SCW-1:0] sin_d [e2q_pkg::NLANE];
	logic signed [SCW-1:0] cos_d [e2q_pkg::NLANE];
	logic signed [SCW-1:0] sin_s1 [e2q_pkg::NLANE];
	logic signed [SCW-1:0] cos_s1 [e2q_pkg::NLANE];

	always_comb begin
		logic signed [e2q_pkg::CW-1:0] xn, yn, xs, ys;
		for (int k = 0; k < e2q_pkg::NLANE; k++) begin
			xn = lanes_in[k].flip ? -lanes_in[k].x : lanes_in[k].x;
			yn = lanes_in[k].flip ? -lanes_in[k].y : lanes_in[k].y;
			xs = xn >>> 8;
			ys = yn >>> 8;
			cos_d[k] = xs[SCW-1:0];
			sin_d[k] = ys[SCW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s1 <= sin_d;
			cos_s1 <= cos_d;
		end
	end

	// Stage 2: roll-pitch products, yaw terms carried along
	logic signed [P1W-1:0] cc_s2, ss_s2, sc_s2, cs_s2;
	logic signed [SCW-1:0] sy_s2, cy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s2 <= P1W'(cos_s1[e2q_pkg::ROLL]) * P1W'(cos_s1[e2q_pkg::PITCH]);
			ss_s2 <= P1W'(sin_s1[e2q_pkg::ROLL]) * P1W'(sin_s1[e2q_pkg::PITCH]);
			sc_s2 <= P1W'(sin_s1[e2q_pkg::ROLL]) * P1W'(cos_s1[e2q_pkg::PITCH]);
			cs_s2 <= P1W'(cos_s1[e2q_pkg::ROLL]) * P1W'(sin_s1[e2q_pkg::PITCH]);
			sy_s2 <= sin_s1[e2q_pkg::YAW];
			cy_s2 <= cos_s1[e2q_pkg::YAW];
		end
	end

	// Stage 3: products with the yaw terms (Q48)
	logic signed [P2W-1:0] cc_cy_s3, ss_sy_s3, sc_cy_s3, cs_sy_s3;
	logic signed [P2W-1:0] cs_cy_s3, sc_sy_s3, cc_sy_s3, ss_cy_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			cc_cy_s3 <= P2W'(cc_s2) * P2W'(cy_s2);
			ss_sy_s3 <= P2W'(ss_s2) * P2W'(sy_s2);
			sc_cy_s3 <= P2W'(sc_s2) * P2W'(cy_s2);
			cs_sy_s3 <= P2W'(cs_s2) * P2W'(sy_s2);
			cs_cy_s3 <= P2W'(cs_s2) * P2W'(cy_s2);
			sc_sy_s3 <= P2W'(sc_s2) * P2W'(sy_s2);
			cc_sy_s3 <= P2W'(cc_s2) * P2W'(sy_s2);
			ss_cy_s3 <= P2W'(ss_s2) * P2W'(cy_s2);
		end
	end

	// Stage 4: sum, floor to Q14, clamp to +-1
	function automatic logic signed [e2q_pkg::AW-1:0] to_q14(
		input logic signed [SUMW-1:0] v
	);
		logic signed [SUMW-1:0] sh;
		logic signed [SHW-1:0]  t;
		sh = v >>> e2q_pkg::OUT_SHIFT;
		t  = sh[SHW-1:0];
		if (t > e2q_pkg::QUAT_ONE) begin
			t = e2q_pkg::QUAT_ONE;
		end else if (t < -e2q_pkg::QUAT_ONE) begin
			t = -e2q_pkg::QUAT_ONE;
		end
		return t[e2q_pkg::AW-1:0];
	endfunction

	logic signed [SUMW-1:0] sum_w, sum_x, sum_y, sum_z;
	logic signed [e2q_pkg::AW-1:0] w_s4, x_s4, y_s4, z_s4;

	assign sum_w = SUMW'(cc_cy_s3) + SUMW'(ss_sy_s3);
	assign sum_x = SUMW'(sc_cy_s3) - SUMW'(cs_sy_s3);
	assign sum_y = SUMW'(cs_cy_s3) + SUMW'(sc_sy_s3);
	assign sum_z = SUMW'(cc_sy_s3) - SUMW'(ss_cy_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			w_s4 <= to_q14(sum_w);
			x_s4 <= to_q14(sum_x);
			y_s4 <= to_q14(sum_y);
			z_s4 <= to_q14(sum_z);
		end
	end

	// Valid bits down the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_v  = v_s4;
	assign quat_w = w_s4;
	assign quat_x = x_s4;
	assign quat_y = y_s4;
	assign quat_z = z_s4;

endmodule

`default_nettype wire

### hw/rtl/euler_to_quaternion.sv
// Throughput: one item per cycle; the whole pipeline advances together and
// holds only while a finished item waits at the output with out_stall high.
// Each CORDIC cell in the row does one micro-rotation.
// Reset: arst_n clears all valid bits asynchronously; no item is held after it.
// ----------------------------------------------------------------------------
// euler_to_quaternion: ZYX Euler angles to unit quaternion
// Fold stage, a row of CORDIC cells for the three half angles, then the
// quaternion product and saturation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_quaternion #(
	parameter int unsigned CORDIC_STAGES = 14
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [e2q_pkg::AW-1:0]     roll_angle,
	input  wire logic signed [e2q_pkg::AW-1:0]     pitch_angle,
	input  wire logic signed [e2q_pkg::AW-1:0]     yaw_angle,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [e2q_pkg::AW-1:0]          quat_w,
	output logic signed [e2q_pkg::AW-1:0]          quat_x,
	output logic signed [e2q_pkg::AW-1:0]          quat_y,
	output logic signed [e2q_pkg::AW-1:0]          quat_z
);

	logic            en;
	logic            v_chain [CORDIC_STAGES+1];
	e2q_pkg::lanes_t lanes_chain [CORDIC_STAGES+1];

	// Pipeline advances unless the output item is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	e2q_fold u_fold (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_v        (in_valid),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle),
		.out_v       (v_chain[0]),
		.lanes_out   (lanes_chain[0])
	);

	// Row of CORDIC cells
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		e2q_cordic_cell #(
			.STAGE (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_v      (v_chain[i]),
			.lanes_in  (lanes_chain[i]),
			.out_v     (v_chain[i+1]),
			.lanes_out (lanes_chain[i+1])
		);
	end

	e2q_quat_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_chain[CORDIC_STAGES]),
		.lanes_in (lanes_chain[CORDIC_STAGES]),
		.out_v    (out_valid),
		.quat_w   (quat_w),
		.quat_x   (quat_x),
		.quat_y   (quat_y),
		.quat_z   (quat_z)
	);

endmodule

`default_nettype wire
